### design/tfn_pkg.sv
// shared constants and sideband type for the triangle face normal core
// no dependencies; used by tfn_sqrt_pipe, tfn_div_pipe and the top level
package tfn_pkg;

   localparam int NORM_W = 31;
   localparam int SUM_W = 64;
   localparam int ROOT_W = 32;
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;
   localparam int DIV_STEPS_PER_STAGE = 2;

   typedef struct packed {
      logic                   valid;
      logic                   gen;
      logic                   degen;
      logic [2:0]             sign;
      logic [2:0][NORM_W-1:0] mag;
   } tfn_side_type;

endpackage

### design/tfn_sqrt_pipe.sv
// pipelined integer square root, two result bits per stage
// depends on tfn_pkg
module tfn_sqrt_pipe (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [tfn_pkg::SUM_W-1:0]   radicand,
   output logic [tfn_pkg::ROOT_W-1:0]  root
);

   localparam int RW = tfn_pkg::ROOT_W + 3;
   localparam int STG = tfn_pkg::SQRT_STAGES;
   localparam int SPS = tfn_pkg::SQRT_STEPS_PER_STAGE;

   logic [tfn_pkg::SUM_W-1:0]  v_in [STG];
   logic [tfn_pkg::SUM_W-1:0]  v_ff [STG];
   logic [RW-1:0]              rem_in [STG];
   logic [RW-1:0]              rem_ff [STG];
   logic [tfn_pkg::ROOT_W-1:0] root_in [STG];
   logic [tfn_pkg::ROOT_W-1:0] root_ff [STG];

   always_comb begin
      logic [tfn_pkg::SUM_W-1:0]  v;
      logic [RW-1:0]              rem;
      logic [RW-1:0]              rn;
      logic [RW-1:0]              trial;
      logic [tfn_pkg::ROOT_W-1:0] rt;
      for (int st = 0; st < STG; st++) begin
         if (st == 0) begin
            v = radicand;
            rem = '0;
            rt = '0;
         end else begin
            v = v_ff[st-1];
            rem = rem_ff[st-1];
            rt = root_ff[st-1];
         end
         for (int j = 0; j < SPS; j++) begin
            rn = {rem[RW-3:0], v[tfn_pkg::SUM_W-1 -: 2]};
            trial = RW'({rt, 2'b01});
            if (rn >= trial) begin
               rem = rn - trial;
               rt = {rt[tfn_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem = rn;
               rt = {rt[tfn_pkg::ROOT_W-2:0], 1'b0};
            end
            v = v << 2;
         end
         v_in[st] = v;
         rem_in[st] = rem;
         root_in[st] = rt;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int st = 0; st < STG; st++) begin
            v_ff[st] <= v_in[st];
            rem_ff[st] <= rem_in[st];
            root_ff[st] <= root_in[st];
         end
      end
   end

   assign root = root_ff[STG-1];

endmodule

### design/tfn_div_pipe.sv
// pipelined restoring divider: round(mag / len) with FRAC_BITS fraction bits
// depends on tfn_pkg
module tfn_div_pipe #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [tfn_pkg::NORM_W-1:0]  mag,
   input  logic [tfn_pkg::ROOT_W-1:0]  len,
   output logic [FRAC_BITS:0]          quot
);

   localparam int QW = FRAC_BITS + 1;
   localparam int DW = tfn_pkg::ROOT_W + 1;
   localparam int NUMW = tfn_pkg::NORM_W + QW + 1;
   localparam int SPS = tfn_pkg::DIV_STEPS_PER_STAGE;
   localparam int DS = (QW + SPS - 1) / SPS;

   logic [NUMW-1:0] num;
   logic [DW-1:0]   rem0_in, rem0_ff, d0_in, d0_ff;
   logic [QW-1:0]   lo0_in, lo0_ff;

   logic [DW-1:0] rem_in [DS];
   logic [DW-1:0] rem_ff [DS];
   logic [DW-1:0] d_in [DS];
   logic [DW-1:0] d_ff [DS];
   logic [QW-1:0] lo_in [DS];
   logic [QW-1:0] lo_ff [DS];
   logic [QW-1:0] q_in [DS];
   logic [QW-1:0] q_ff [DS];

   // numerator carries the half-divisor so the quotient rounds half up
   always_comb begin
      num = (NUMW'(mag) << QW) + NUMW'(len);
      rem0_in = DW'(num[NUMW-1:QW]);
      lo0_in = num[QW-1:0];
      d0_in = {len, 1'b0};
   end

   always_comb begin
      logic [DW-1:0] rem;
      logic [DW-1:0] d;
      logic [QW-1:0] lo;
      logic [QW-1:0] q;
      logic [DW:0]   r2;
      logic          qb;
      for (int st = 0; st < DS; st++) begin
         if (st == 0) begin
            rem = rem0_ff;
            d = d0_ff;
            lo = lo0_ff;
            q = '0;
         end else begin
            rem = rem_ff[st-1];
            d = d_ff[st-1];
            lo = lo_ff[st-1];
            q = q_ff[st-1];
         end
         for (int j = 0; j < SPS; j++) begin
            if (st * SPS + j < QW) begin
               r2 = {rem, lo[QW-1]};
               qb = (r2 >= {1'b0, d});
               if (qb) begin
                  r2 = r2 - {1'b0, d};
               end
               rem = r2[DW-1:0];
               lo = lo << 1;
               q = {q[QW-2:0], qb};
            end
         end
         rem_in[st] = rem;
         d_in[st] = d;
         lo_in[st] = lo;
         q_in[st] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem0_ff <= rem0_in;
         d0_ff <= d0_in;
         lo0_ff <= lo0_in;
         for (int st = 0; st < DS; st++) begin
            rem_ff[st] <= rem_in[st];
            d_ff[st] <= d_in[st];
            lo_ff[st] <= lo_in[st];
            q_ff[st] <= q_in[st];
         end
      end
   end

   assign quot = q_ff[DS-1];

endmodule

### design/triangle_face_normal_core.sv
// triangle face normal core: edge cross product, normalize, square root, divide
// depends on tfn_pkg, tfn_sqrt_pipe and tfn_div_pipe
//
// usage:
//   req_* carries one triangle per item: three vertices in signed fixed point
//   and three normal indices. rsp_* carries one result per item, in order.
//   an item is taken on a clock edge with valid high and stall low.
//   when any index is all ones the unit normal of the face is computed
//   (counter-clockwise winding) and rsp_normal_generated is set; a zero cross
//   product gives a zero normal with rsp_degenerate_face set. otherwise the
//   normal is zero and both flags are clear.
//   throughput: one item per clock while no stall is raised. there are 10 front
//   stages, 16 square root stages, (NORMAL_FRAC_BITS + 2) / 2 + 1 divider
//   stages and the output register.
//   the pipeline moves as one: while rsp_valid is high and rsp_stall is high
//   every stage holds and req_stall is raised; nothing is dropped or repeated.
//   reset clears all valid bits; the first item may be sent the cycle after.
module triangle_face_normal_core #(
   parameter int COORD_WIDTH = 24,
   parameter int NORMAL_FRAC_BITS = 14,
   parameter int INDEX_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_z,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_z,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_z,
   input  logic [INDEX_WIDTH-1:0]        req_normal_index_first,
   input  logic [INDEX_WIDTH-1:0]        req_normal_index_second,
   input  logic [INDEX_WIDTH-1:0]        req_normal_index_third,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_unit_normal_x,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_unit_normal_y,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_unit_normal_z,
   output logic                          rsp_normal_generated,
   output logic                          rsp_degenerate_face
);

   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;
   localparam int SW = (EW > 32) ? 32 : EW;
   localparam int PW = 2 * SW;
   localparam int XW = PW + 1;
   localparam int MW = XW;
   localparam int NG = (MW + 7) / 8;
   localparam int GW = $clog2(NG);
   localparam int BLW = $clog2(NG * 8 + 1);
   localparam int NW = tfn_pkg::NORM_W;
   localparam int QW = NORMAL_FRAC_BITS + 1;
   localparam int OW = NORMAL_FRAC_BITS + 2;
   localparam int SQS = tfn_pkg::SQRT_STAGES;
   localparam int DIV_LAT = (QW + tfn_pkg::DIV_STEPS_PER_STAGE - 1)
                            / tfn_pkg::DIV_STEPS_PER_STAGE + 1;

   logic adv;
   logic [CW-1:0] va [3];
   logic [CW-1:0] vb [3];
   logic [CW-1:0] vc [3];

   assign va[0] = req_vertex_a_x;
   assign va[1] = req_vertex_a_y;
   assign va[2] = req_vertex_a_z;
   assign vb[0] = req_vertex_b_x;
   assign vb[1] = req_vertex_b_y;
   assign vb[2] = req_vertex_b_z;
   assign vc[0] = req_vertex_c_x;
   assign vc[1] = req_vertex_c_y;
   assign vc[2] = req_vertex_c_z;

   // stage 1: edges from the first vertex
   logic                 s1_valid_in, s1_valid_ff, s1_gen_in, s1_gen_ff;
   logic signed [EW-1:0] s1_e_in [6];
   logic signed [EW-1:0] s1_e_ff [6];

   always_comb begin
      s1_valid_in = req_valid;
      s1_gen_in = (req_normal_index_first == {INDEX_WIDTH{1'b1}})
                  || (req_normal_index_second == {INDEX_WIDTH{1'b1}})
                  || (req_normal_index_third == {INDEX_WIDTH{1'b1}});
      for (int i = 0; i < 3; i++) begin
         s1_e_in[i] = $signed({vb[i][CW-1], vb[i]}) - $signed({va[i][CW-1], va[i]});
         s1_e_in[i+3] = $signed({vc[i][CW-1], vc[i]}) - $signed({va[i][CW-1], va[i]});
      end
   end

   // stage 2: common shrink so edge magnitudes stay below 2^31
   logic                 s2_valid_ff, s2_gen_ff;
   logic signed [SW-1:0] s2_e_in [6];
   logic signed [SW-1:0] s2_e_ff [6];

   always_comb begin
      logic [EW-1:0] emag [6];
      logic [EW-1:0] ormag;
      logic [1:0]    sh;
      logic [EW:0]   ext;
      logic [EW:0]   tmp;
      ormag = '0;
      for (int i = 0; i < 6; i++) begin
         emag[i] = s1_e_ff[i][EW-1] ? (~s1_e_ff[i] + 1'b1) : s1_e_ff[i];
         ormag = ormag | emag[i];
      end
      sh = '0;
      for (int k = 31; k < EW; k++) begin
         if (ormag[k]) begin
            sh = 2'(k - 30);
         end
      end
      for (int i = 0; i < 6; i++) begin
         ext = {1'b0, emag[i] >> sh};
         tmp = s1_e_ff[i][EW-1] ? (~ext + 1'b1) : ext;
         s2_e_in[i] = tmp[SW-1:0];
      end
   end

   // stage 3: six partial products
   logic                 s3_valid_ff, s3_gen_ff;
   logic signed [PW-1:0] s3_p_in [6];
   logic signed [PW-1:0] s3_p_ff [6];

   always_comb begin
      s3_p_in[0] = s2_e_ff[1] * s2_e_ff[5];
      s3_p_in[1] = s2_e_ff[2] * s2_e_ff[4];
      s3_p_in[2] = s2_e_ff[2] * s2_e_ff[3];
      s3_p_in[3] = s2_e_ff[0] * s2_e_ff[5];
      s3_p_in[4] = s2_e_ff[0] * s2_e_ff[4];
      s3_p_in[5] = s2_e_ff[1] * s2_e_ff[3];
   end

   // stage 4: cross product
   logic          s4_valid_ff, s4_gen_ff;
   logic [XW-1:0] s4_c_in [3];
   logic [XW-1:0] s4_c_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_c_in[i] = {s3_p_ff[2*i][PW-1], s3_p_ff[2*i]}
                      - {s3_p_ff[2*i+1][PW-1], s3_p_ff[2*i+1]};
      end
   end

   // stage 5: magnitudes and signs
   logic          s5_valid_ff, s5_gen_ff;
   logic [MW-1:0] s5_mag_in [3];
   logic [MW-1:0] s5_mag_ff [3];
   logic [2:0]    s5_sign_in, s5_sign_ff;
   logic [MW-1:0] s5_or_in, s5_or_ff;

   always_comb begin
      s5_or_in = '0;
      for (int i = 0; i < 3; i++) begin
         s5_sign_in[i] = s4_c_ff[i][XW-1];
         s5_mag_in[i] = s4_c_ff[i][XW-1] ? (~s4_c_ff[i] + 1'b1) : s4_c_ff[i];
         s5_or_in = s5_or_in | s5_mag_in[i];
      end
   end

   // stage 6: highest nonzero byte of the combined magnitude
   logic          s6_valid_ff, s6_gen_ff, s6_degen_in, s6_degen_ff;
   logic [MW-1:0] s6_mag_ff [3];
   logic [2:0]    s6_sign_ff;
   logic [GW-1:0] s6_grp_in, s6_grp_ff;
   logic [7:0]    s6_byte_in, s6_byte_ff;

   always_comb begin
      logic [NG*8-1:0] pad;
      pad = {{(NG*8-MW){1'b0}}, s5_or_ff};
      s6_grp_in = '0;
      s6_byte_in = '0;
      for (int k = 0; k < NG; k++) begin
         if (|pad[k*8 +: 8]) begin
            s6_grp_in = GW'(k);
            s6_byte_in = pad[k*8 +: 8];
         end
      end
      s6_degen_in = (s5_or_ff == '0);
   end

   // stage 7: bit length
   logic           s7_valid_ff, s7_gen_ff, s7_degen_ff;
   logic [MW-1:0]  s7_mag_ff [3];
   logic [2:0]     s7_sign_ff;
   logic [BLW-1:0] s7_bl_in, s7_bl_ff;

   always_comb begin
      logic [3:0] bb;
      bb = '0;
      for (int j = 0; j < 8; j++) begin
         if (s6_byte_ff[j]) begin
            bb = 4'(j + 1);
         end
      end
      s7_bl_in = BLW'({s6_grp_ff, 3'b000}) + BLW'(bb);
   end

   // stage 8: normalize so the largest magnitude lies in [2^30, 2^31)
   tfn_pkg::tfn_side_type s8_side_in, s8_side_ff;

   always_comb begin
      logic [MW+NW-1:0] wide;
      logic [MW-1:0]    rsh;
      s8_side_in.valid = s7_valid_ff;
      s8_side_in.gen = s7_gen_ff;
      s8_side_in.degen = s7_degen_ff;
      s8_side_in.sign = s7_sign_ff;
      for (int i = 0; i < 3; i++) begin
         wide = (MW+NW)'(s7_mag_ff[i]);
         rsh = s7_mag_ff[i];
         if (s7_bl_ff > BLW'(NW)) begin
            rsh = s7_mag_ff[i] >> (s7_bl_ff - BLW'(NW));
            s8_side_in.mag[i] = rsh[NW-1:0];
         end else begin
            wide = wide << (BLW'(NW) - s7_bl_ff);
            s8_side_in.mag[i] = wide[NW-1:0];
         end
      end
   end

   // stage 9 and 10: sum of squares
   tfn_pkg::tfn_side_type     s9_side_ff, s10_side_ff;
   logic [2*NW-1:0]           s9_sq_in [3];
   logic [2*NW-1:0]           s9_sq_ff [3];
   logic [tfn_pkg::SUM_W-1:0] s10_sum_in, s10_sum_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s9_sq_in[i] = s8_side_ff.mag[i] * s8_side_ff.mag[i];
      end
      s10_sum_in = tfn_pkg::SUM_W'(s9_sq_ff[0]) + tfn_pkg::SUM_W'(s9_sq_ff[1])
                   + tfn_pkg::SUM_W'(s9_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_side_ff <= '0;
         s9_side_ff <= '0;
         s10_side_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_side_ff <= s8_side_in;
         s9_side_ff <= s8_side_ff;
         s10_side_ff <= s9_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_gen_ff <= s1_gen_in;
         s2_gen_ff <= s1_gen_ff;
         s3_gen_ff <= s2_gen_ff;
         s4_gen_ff <= s3_gen_ff;
         s5_gen_ff <= s4_gen_ff;
         s6_gen_ff <= s5_gen_ff;
         s7_gen_ff <= s6_gen_ff;
         for (int i = 0; i < 6; i++) begin
            s1_e_ff[i] <= s1_e_in[i];
            s2_e_ff[i] <= s2_e_in[i];
            s3_p_ff[i] <= s3_p_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            s4_c_ff[i] <= s4_c_in[i];
            s5_mag_ff[i] <= s5_mag_in[i];
            s6_mag_ff[i] <= s5_mag_ff[i];
            s7_mag_ff[i] <= s6_mag_ff[i];
            s9_sq_ff[i] <= s9_sq_in[i];
         end
         s5_sign_ff <= s5_sign_in;
         s5_or_ff <= s5_or_in;
         s6_sign_ff <= s5_sign_ff;
         s6_grp_ff <= s6_grp_in;
         s6_byte_ff <= s6_byte_in;
         s6_degen_ff <= s6_degen_in;
         s7_sign_ff <= s6_sign_ff;
         s7_degen_ff <= s6_degen_ff;
         s7_bl_ff <= s7_bl_in;
         s10_sum_ff <= s10_sum_in;
      end
   end

   // square root and its sideband
   logic [tfn_pkg::ROOT_W-1:0] len;
   tfn_pkg::tfn_side_type      sq_side_ff [SQS];

   tfn_sqrt_pipe u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (s10_sum_ff),
      .root     (len)
   );

   // dividers and their sideband
   logic [QW-1:0]         quot [3];
   tfn_pkg::tfn_side_type div_side_ff [DIV_LAT];

   for (genvar g = 0; g < 3; g++) begin : g_div
      tfn_div_pipe #(
         .FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_div (
         .clock  (clock),
         .enable (adv),
         .mag    (sq_side_ff[SQS-1].mag[g]),
         .len    (len),
         .quot   (quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQS; k++) begin
            sq_side_ff[k] <= '0;
         end
         for (int k = 0; k < DIV_LAT; k++) begin
            div_side_ff[k] <= '0;
         end
      end else if (adv) begin
         sq_side_ff[0] <= s10_side_ff;
         for (int k = 1; k < SQS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
         div_side_ff[0] <= sq_side_ff[SQS-1];
         for (int k = 1; k < DIV_LAT; k++) begin
            div_side_ff[k] <= div_side_ff[k-1];
         end
      end
   end

   // output register
   logic          rsp_valid_in, rsp_valid_ff;
   logic          rsp_gen_in, rsp_gen_ff, rsp_degen_in, rsp_degen_ff;
   logic [OW-1:0] rsp_n_in [3];
   logic [OW-1:0] rsp_n_ff [3];

   always_comb begin
      logic [OW-1:0] ext;
      rsp_valid_in = div_side_ff[DIV_LAT-1].valid;
      rsp_gen_in = div_side_ff[DIV_LAT-1].gen;
      rsp_degen_in = div_side_ff[DIV_LAT-1].gen && div_side_ff[DIV_LAT-1].degen;
      for (int i = 0; i < 3; i++) begin
         ext = {1'b0, quot[i]};
         rsp_n_in[i] = div_side_ff[DIV_LAT-1].sign[i] ? (~ext + 1'b1) : ext;
         if (!div_side_ff[DIV_LAT-1].gen || div_side_ff[DIV_LAT-1].degen) begin
            rsp_n_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_gen_ff <= rsp_gen_in;
         rsp_degen_ff <= rsp_degen_in;
         for (int i = 0; i < 3; i++) begin
            rsp_n_ff[i] <= rsp_n_in[i];
         end
      end
   end

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_unit_normal_x = rsp_n_ff[0];
   assign rsp_unit_normal_y = rsp_n_ff[1];
   assign rsp_unit_normal_z = rsp_n_ff[2];
   assign rsp_normal_generated = rsp_gen_ff;
   assign rsp_degenerate_face = rsp_degen_ff;

   // an accepted item always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted item missing from first stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_degenerate_face || rsp_normal_generated))
      else $error("degenerate flag without generated normal");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!rsp_normal_generated || rsp_degenerate_face)) |->
      (rsp_unit_normal_x == '0 && rsp_unit_normal_y == '0 && rsp_unit_normal_z == '0))
      else $error("nonzero normal where none was made");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_normal_generated && !rsp_degenerate_face) |->
      (rsp_unit_normal_x != '0 || rsp_unit_normal_y != '0 || rsp_unit_normal_z != '0))
      else $error("zero normal for a nondegenerate face");

endmodule
